// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker of the adjacency builder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define ELCSR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("elcsr: implication check failed");

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define ELCSR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("elcsr: next-cycle check failed");

`endif

// ----- rtl/core/elcsr_pkg.sv -----
// Shared types and constants of the edge-list to adjacency-table builder.
package elcsr_pkg;

	// Field widths of the ports
	localparam int OP_W       = 3;
	localparam int END_W      = 10;
	localparam int INDEX_W    = 12;
	localparam int VCOUNT_W   = 11;
	localparam int STATUS_W   = 2;
	localparam int OFFSET_W   = 13;
	localparam int EDGE_NUM_W = 11;

	// Operation codes
	localparam logic [OP_W-1:0] OP_START     = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD       = 3'd1;
	localparam logic [OP_W-1:0] OP_BUILD     = 3'd2;
	localparam logic [OP_W-1:0] OP_READ_OFF  = 3'd3;
	localparam logic [OP_W-1:0] OP_READ_SLOT = 3'd4;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
	localparam logic [STATUS_W-1:0] ST_UNBUILT = 2'd3;

	// One result word
	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [OFFSET_W-1:0]   offset_value;
		logic [END_W-1:0]      neighbor_vertex;
		logic [EDGE_NUM_W-1:0] edge_number;
	} elcsr_result_t;

	// Read and write strobes of the table memories
	typedef struct packed {
		logic deg_re;
		logic deg_we;
		logic edge_re;
		logic edge_we;
		logic pos_re;
		logic pos_we;
		logic slot_re;
		logic slot_we;
	} elcsr_mem_ctl_t;

endpackage

// ----- rtl/core/elcsr_store.sv -----
// Table memories: vertex counters/offsets, stored edges, positions, adjacency slots.
module elcsr_store #(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_EDGES    = 2048,
	localparam int VAW   = $clog2(MAX_VERTICES + 1),
	localparam int DW    = $clog2(2 * MAX_EDGES + 1),
	localparam int EAW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
	localparam int SLOTS = 2 * MAX_EDGES,
	localparam int SAW   = $clog2(SLOTS)
) (
	input  logic                               clk,
	input  elcsr_pkg::elcsr_mem_ctl_t          ctl,
	input  logic [VAW-1:0]                     deg_ra0,
	input  logic [VAW-1:0]                     deg_ra1,
	input  logic [VAW-1:0]                     deg_wa,
	input  logic [DW-1:0]                      deg_wd,
	output logic [DW-1:0]                      deg_rd0,
	output logic [DW-1:0]                      deg_rd1,
	input  logic [EAW-1:0]                     edge_ra,
	input  logic [EAW-1:0]                     edge_wa,
	input  logic [2*elcsr_pkg::END_W-1:0]      edge_wd,
	output logic [2*elcsr_pkg::END_W-1:0]      edge_rd,
	input  logic [EAW-1:0]                     pos_ra,
	input  logic [EAW-1:0]                     pos_wa,
	input  logic [2*DW-1:0]                    pos_wd,
	output logic [2*DW-1:0]                    pos_rd,
	input  logic [SAW-1:0]                     slot_ra,
	input  logic [SAW-1:0]                     slot_wa,
	input  logic [elcsr_pkg::END_W+EAW-1:0]    slot_wd,
	output logic [elcsr_pkg::END_W+EAW-1:0]    slot_rd
);
	import elcsr_pkg::*;

	localparam int DEG_DEPTH = MAX_VERTICES + 1;

	logic [DW-1:0]        deg_mem  [DEG_DEPTH];
	logic [2*END_W-1:0]   edge_mem [MAX_EDGES];
	logic [2*DW-1:0]      pos_mem  [MAX_EDGES];
	logic [END_W+EAW-1:0] slot_mem [SLOTS];

	// Counter memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (ctl.deg_we) begin
			deg_mem[deg_wa] <= deg_wd;
		end
		if (ctl.deg_re) begin
			deg_rd0 <= deg_mem[deg_ra0];
			deg_rd1 <= deg_mem[deg_ra1];
		end
	end

	// Stored edge ends
	always_ff @(posedge clk) begin
		if (ctl.edge_we) begin
			edge_mem[edge_wa] <= edge_wd;
		end
		if (ctl.edge_re) begin
			edge_rd <= edge_mem[edge_ra];
		end
	end

	// Positions of both ends within their vertex runs
	always_ff @(posedge clk) begin
		if (ctl.pos_we) begin
			pos_mem[pos_wa] <= pos_wd;
		end
		if (ctl.pos_re) begin
			pos_rd <= pos_mem[pos_ra];
		end
	end

	// Adjacency slots: neighbour vertex and edge number
	always_ff @(posedge clk) begin
		if (ctl.slot_we) begin
			slot_mem[slot_wa] <= slot_wd;
		end
		if (ctl.slot_re) begin
			slot_rd <= slot_mem[slot_ra];
		end
	end

endmodule

// ----- rtl/core/elcsr_seq.sv -----
// Sequencer with the shared adder: decodes ops and walks the tables for a build.
module elcsr_seq #(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_EDGES    = 2048,
	localparam int VAW   = $clog2(MAX_VERTICES + 1),
	localparam int DW    = $clog2(2 * MAX_EDGES + 1),
	localparam int EAW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
	localparam int SLOTS = 2 * MAX_EDGES,
	localparam int SAW   = $clog2(SLOTS)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [elcsr_pkg::VCOUNT_W-1:0]     nv,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [elcsr_pkg::OP_W-1:0]         op,
	input  logic [elcsr_pkg::END_W-1:0]        end_a,
	input  logic [elcsr_pkg::END_W-1:0]        end_b,
	input  logic [elcsr_pkg::INDEX_W-1:0]      read_index,
	output elcsr_pkg::elcsr_result_t           res,
	output logic                               res_valid,
	input  logic                               res_take,
	output elcsr_pkg::elcsr_mem_ctl_t          ctl,
	output logic [VAW-1:0]                     deg_ra0,
	output logic [VAW-1:0]                     deg_ra1,
	output logic [VAW-1:0]                     deg_wa,
	output logic [DW-1:0]                      deg_wd,
	input  logic [DW-1:0]                      deg_rd0,
	input  logic [DW-1:0]                      deg_rd1,
	output logic [EAW-1:0]                     edge_ra,
	output logic [EAW-1:0]                     edge_wa,
	output logic [2*elcsr_pkg::END_W-1:0]      edge_wd,
	input  logic [2*elcsr_pkg::END_W-1:0]      edge_rd,
	output logic [EAW-1:0]                     pos_ra,
	output logic [EAW-1:0]                     pos_wa,
	output logic [2*DW-1:0]                    pos_wd,
	input  logic [2*DW-1:0]                    pos_rd,
	output logic [SAW-1:0]                     slot_ra,
	output logic [SAW-1:0]                     slot_wa,
	output logic [elcsr_pkg::END_W+EAW-1:0]    slot_wd,
	input  logic [elcsr_pkg::END_W+EAW-1:0]    slot_rd
);
	import elcsr_pkg::*;

	localparam int ECW = $clog2(MAX_EDGES + 1);

	// Sequencer states
	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_RD_OFF  = 5'd1;
	localparam logic [4:0] S_RD_SLOT = 5'd2;
	localparam logic [4:0] S_CHK_RD  = 5'd3;
	localparam logic [4:0] S_CHK_EV  = 5'd4;
	localparam logic [4:0] S_CLR     = 5'd5;
	localparam logic [4:0] S_RC_RD   = 5'd6;
	localparam logic [4:0] S_RC_DEG  = 5'd7;
	localparam logic [4:0] S_RC_A    = 5'd8;
	localparam logic [4:0] S_RC_B    = 5'd9;
	localparam logic [4:0] S_PFX_RD  = 5'd10;
	localparam logic [4:0] S_PFX_WR  = 5'd11;
	localparam logic [4:0] S_SC_RD   = 5'd12;
	localparam logic [4:0] S_SC_DEG  = 5'd13;
	localparam logic [4:0] S_SC_A    = 5'd14;
	localparam logic [4:0] S_SC_B    = 5'd15;
	localparam logic [4:0] S_RESP    = 5'd16;

	logic [4:0]          state_q;
	logic [EAW-1:0]      i_q;
	logic [VAW-1:0]      j_q;
	logic [DW-1:0]       run_q;
	logic [DW-1:0]       pos0_q;
	logic [DW-1:0]       pos1_q;
	logic [ECW-1:0]      edge_count_q;
	logic                built_q;
	logic [VCOUNT_W-1:0] built_nv_q;
	elcsr_result_t       res_q;

	logic [END_W-1:0] ends_a;
	logic [END_W-1:0] ends_b;
	logic [DW-1:0]    pos_rd0;
	logic [DW-1:0]    pos_rd1;
	logic [DW-1:0]    add_x;
	logic [DW-1:0]    add_y;
	logic [DW-1:0]    sum;
	logic             add_in_range;
	logic             edges_full;
	logic             off_in_range;
	logic             slot_in_range;
	logic             ends_in_range;
	logic             last_edge;
	logic             last_vertex;
	elcsr_result_t    acc_res;
	logic [4:0]       acc_next;

	// Unpack the registered memory words
	assign ends_a  = edge_rd[2*END_W-1:END_W];
	assign ends_b  = edge_rd[END_W-1:0];
	assign pos_rd0 = pos_rd[2*DW-1:DW];
	assign pos_rd1 = pos_rd[DW-1:0];

	// Range checks of the incoming word and of a stored edge, plus the full and last-item flags
	assign add_in_range  = (VCOUNT_W'(end_a) < nv) && (VCOUNT_W'(end_b) < nv);
	assign edges_full    = edge_count_q == ECW'(MAX_EDGES);
	assign off_in_range  = (32'(read_index) <= 32'(built_nv_q))
		&& (32'(read_index) <= 32'(MAX_VERTICES));
	assign slot_in_range = (32'(read_index) < (32'(edge_count_q) << 1))
		&& (32'(read_index) < 32'(SLOTS));
	assign ends_in_range = (VCOUNT_W'(ends_a) < nv) && (VCOUNT_W'(ends_b) < nv);
	assign last_edge     = (ECW'(i_q) + ECW'(1)) == edge_count_q;
	assign last_vertex   = 32'(j_q) == 32'(nv);

	assign in_ready  = state_q == S_IDLE;
	assign res_valid = state_q == S_RESP;
	assign res       = res_q;

	// Decode the waiting word: its early status and the state it leads to
	always_comb begin
		acc_res  = '0;
		acc_next = S_RESP;
		unique case (op)
			OP_START: ;
			OP_ADD: begin
				if (!add_in_range) begin
					acc_res.status = ST_RANGE;
				end else if (edges_full) begin
					acc_res.status = ST_FULL;
				end
			end
			OP_BUILD: begin
				if (edge_count_q != '0 && nv != '0) begin
					acc_next = S_CHK_RD;
				end
			end
			OP_READ_OFF: begin
				if (!built_q) begin
					acc_res.status = ST_UNBUILT;
				end else if (!off_in_range) begin
					acc_res.status = ST_RANGE;
				end else begin
					acc_next = S_RD_OFF;
				end
			end
			OP_READ_SLOT: begin
				if (!built_q) begin
					acc_res.status = ST_UNBUILT;
				end else if (!slot_in_range) begin
					acc_res.status = ST_RANGE;
				end else begin
					acc_next = S_RD_SLOT;
				end
			end
			default: begin
				acc_res.status = ST_RANGE;
			end
		endcase
	end

	// Shared adder: counter bump, prefix accumulation, slot address
	always_comb begin
		add_x = '0;
		add_y = '0;
		case (state_q)
			S_RC_A: begin
				add_x = deg_rd0;
				add_y = DW'(1);
			end
			S_RC_B: begin
				add_x = pos1_q;
				add_y = DW'(1);
			end
			S_PFX_WR: begin
				add_x = run_q;
				add_y = deg_rd0;
			end
			S_SC_A: begin
				add_x = deg_rd0;
				add_y = pos_rd0;
			end
			S_SC_B: begin
				add_x = deg_rd1;
				add_y = pos_rd1;
			end
			default: ;
		endcase
	end
	assign sum = add_x + add_y;

	// Drive memory strobes and addresses from the state
	always_comb begin
		ctl     = '0;
		deg_ra0 = j_q;
		deg_ra1 = VAW'(ends_b);
		deg_wa  = j_q;
		deg_wd  = '0;
		edge_ra = i_q;
		edge_wa = EAW'(edge_count_q);
		edge_wd = {end_a, end_b};
		pos_ra  = i_q;
		pos_wa  = i_q;
		pos_wd  = {pos0_q, pos1_q};
		slot_ra = SAW'(read_index);
		slot_wa = SAW'(sum);
		slot_wd = {ends_b, i_q};
		unique case (state_q) inside
			S_IDLE: begin
				if (in_valid) begin
					if (op == OP_ADD && add_in_range && !edges_full) begin
						ctl.edge_we = 1'b1;
					end
					if (op == OP_READ_OFF && built_q && off_in_range) begin
						ctl.deg_re = 1'b1;
						deg_ra0    = VAW'(read_index);
					end
					if (op == OP_READ_SLOT && built_q && slot_in_range) begin
						ctl.slot_re = 1'b1;
					end
				end
			end
			S_CHK_RD, S_RC_RD: begin
				ctl.edge_re = 1'b1;
			end
			S_SC_RD: begin
				ctl.edge_re = 1'b1;
				ctl.pos_re  = 1'b1;
			end
			S_RC_DEG, S_SC_DEG: begin
				ctl.deg_re = 1'b1;
				deg_ra0    = VAW'(ends_a);
			end
			S_CLR: begin
				ctl.deg_we = 1'b1;
			end
			S_RC_A: begin
				ctl.deg_we = 1'b1;
				deg_wa     = VAW'(ends_a);
				deg_wd     = sum;
			end
			S_RC_B: begin
				ctl.deg_we = 1'b1;
				ctl.pos_we = 1'b1;
				deg_wa     = VAW'(ends_b);
				deg_wd     = sum;
			end
			S_PFX_RD: begin
				ctl.deg_re = 1'b1;
			end
			S_PFX_WR: begin
				ctl.deg_we = 1'b1;
				deg_wd     = run_q;
			end
			S_SC_A: begin
				ctl.slot_we = 1'b1;
			end
			S_SC_B: begin
				ctl.slot_we = 1'b1;
				slot_wd     = {ends_a, i_q};
			end
			default: ;
		endcase
	end

	// Decode accepted words and step through the build passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			i_q          <= '0;
			j_q          <= '0;
			run_q        <= '0;
			pos0_q       <= '0;
			pos1_q       <= '0;
			edge_count_q <= '0;
			built_q      <= 1'b0;
			built_nv_q   <= '0;
			res_q        <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						res_q   <= acc_res;
						i_q     <= '0;
						j_q     <= '0;
						run_q   <= '0;
						state_q <= acc_next;
						if (op == OP_START) begin
							edge_count_q <= '0;
							built_q      <= 1'b0;
						end else if (op == OP_ADD && acc_res.status == ST_OK) begin
							edge_count_q <= edge_count_q + ECW'(1);
							built_q      <= 1'b0;
						end
					end
				end
				S_RD_OFF: begin
					res_q.offset_value <= OFFSET_W'(deg_rd0);
					state_q            <= S_RESP;
				end
				S_RD_SLOT: begin
					res_q.neighbor_vertex <= slot_rd[END_W+EAW-1:EAW];
					res_q.edge_number     <= EDGE_NUM_W'(slot_rd[EAW-1:0]);
					state_q               <= S_RESP;
				end
				// Check every stored edge against the current vertex count
				S_CHK_RD: begin
					state_q <= S_CHK_EV;
				end
				S_CHK_EV: begin
					if (!ends_in_range) begin
						res_q.status <= ST_RANGE;
						state_q      <= S_RESP;
					end else if (last_edge) begin
						j_q     <= '0;
						state_q <= S_CLR;
					end else begin
						i_q     <= i_q + EAW'(1);
						state_q <= S_CHK_RD;
					end
				end
				// Zero the counters up to and including the vertex count
				S_CLR: begin
					if (last_vertex) begin
						i_q     <= '0;
						state_q <= S_RC_RD;
					end else begin
						j_q <= j_q + VAW'(1);
					end
				end
				// Recount: each end takes its position and bumps its counter
				S_RC_RD: begin
					state_q <= S_RC_DEG;
				end
				S_RC_DEG: begin
					state_q <= S_RC_A;
				end
				S_RC_A: begin
					pos0_q  <= deg_rd0;
					pos1_q  <= (ends_a == ends_b) ? sum : deg_rd1;
					state_q <= S_RC_B;
				end
				S_RC_B: begin
					if (last_edge) begin
						j_q     <= '0;
						run_q   <= '0;
						state_q <= S_PFX_RD;
					end else begin
						i_q     <= i_q + EAW'(1);
						state_q <= S_RC_RD;
					end
				end
				// Exclusive prefix sum over the counters
				S_PFX_RD: begin
					state_q <= S_PFX_WR;
				end
				S_PFX_WR: begin
					run_q <= sum;
					if (last_vertex) begin
						i_q     <= '0;
						state_q <= S_SC_RD;
					end else begin
						j_q     <= j_q + VAW'(1);
						state_q <= S_PFX_RD;
					end
				end
				// Scatter each edge into both of its slots
				S_SC_RD: begin
					state_q <= S_SC_DEG;
				end
				S_SC_DEG: begin
					state_q <= S_SC_A;
				end
				S_SC_A: begin
					state_q <= S_SC_B;
				end
				S_SC_B: begin
					if (last_edge) begin
						built_q    <= 1'b1;
						built_nv_q <= nv;
						state_q    <= S_RESP;
					end else begin
						i_q     <= i_q + EAW'(1);
						state_q <= S_SC_RD;
					end
				end
				S_RESP: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/edge_list_to_csr_builder.sv -----
// Top level of the edge-list to compressed adjacency (CSR) table builder.
// Each input word is one op: start, add edge, build, read offset or read
// adjacency slot, and each gives exactly one result word. The block handles
// one op at a time; a finished result sits in an output register, so the
// next op is accepted while it waits. A build with E stored edges and N
// active vertices runs a range check over the edges, a clearing of N+1
// counters, a recount of both ends of every edge, an exclusive prefix sum
// over N+1 counters and a scatter of each edge into two slots, all paced
// by the single write port of the counter memory and the one adder that
// the recount, prefix and scatter passes share. Build recounts from the
// stored edges, so the counter memory needs no clearing pass after reset
// and start only drops the edge count and the built flag. The vertex_count
// register takes a write in any cycle and is only to be changed while idle.
module edge_list_to_csr_builder #(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_EDGES    = 2048
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [elcsr_pkg::VCOUNT_W-1:0]      vertex_count,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [elcsr_pkg::OP_W-1:0]          op,
	input  logic [elcsr_pkg::END_W-1:0]         end_a,
	input  logic [elcsr_pkg::END_W-1:0]         end_b,
	input  logic [elcsr_pkg::INDEX_W-1:0]       read_index,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [elcsr_pkg::STATUS_W-1:0]      status,
	output logic [elcsr_pkg::OFFSET_W-1:0]      offset_value,
	output logic [elcsr_pkg::END_W-1:0]         neighbor_vertex,
	output logic [elcsr_pkg::EDGE_NUM_W-1:0]    edge_number
);
	import elcsr_pkg::*;

	localparam int VAW   = $clog2(MAX_VERTICES + 1);
	localparam int DW    = $clog2(2 * MAX_EDGES + 1);
	localparam int EAW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int SAW   = $clog2(2 * MAX_EDGES);

	logic [VCOUNT_W-1:0] vertex_count_q;
	logic [VCOUNT_W-1:0] nv;
	logic                out_valid_q;
	elcsr_result_t       out_q;
	elcsr_result_t       res;
	logic                res_valid;
	logic                res_take;
	elcsr_mem_ctl_t      ctl;

	logic [VAW-1:0]       deg_ra0;
	logic [VAW-1:0]       deg_ra1;
	logic [VAW-1:0]       deg_wa;
	logic [DW-1:0]        deg_wd;
	logic [DW-1:0]        deg_rd0;
	logic [DW-1:0]        deg_rd1;
	logic [EAW-1:0]       edge_ra;
	logic [EAW-1:0]       edge_wa;
	logic [2*END_W-1:0]   edge_wd;
	logic [2*END_W-1:0]   edge_rd;
	logic [EAW-1:0]       pos_ra;
	logic [EAW-1:0]       pos_wa;
	logic [2*DW-1:0]      pos_wd;
	logic [2*DW-1:0]      pos_rd;
	logic [SAW-1:0]       slot_ra;
	logic [SAW-1:0]       slot_wa;
	logic [END_W+EAW-1:0] slot_wd;
	logic [END_W+EAW-1:0] slot_rd;

	// Hold the vertex count register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
		end else if (cfg_valid) begin
			vertex_count_q <= vertex_count;
		end
	end

	// Clamp the vertex count to the table size
	assign nv = (32'(vertex_count_q) > 32'(MAX_VERTICES)) ?
		VCOUNT_W'(MAX_VERTICES) : vertex_count_q;

	// Output register: load a result when the slot is free or draining
	assign res_take = !out_valid_q || out_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
			out_q       <= res;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_q.status;
	assign offset_value    = out_q.offset_value;
	assign neighbor_vertex = out_q.neighbor_vertex;
	assign edge_number     = out_q.edge_number;

	elcsr_seq #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.nv         (nv),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.end_a      (end_a),
		.end_b      (end_b),
		.read_index (read_index),
		.res        (res),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.ctl        (ctl),
		.deg_ra0    (deg_ra0),
		.deg_ra1    (deg_ra1),
		.deg_wa     (deg_wa),
		.deg_wd     (deg_wd),
		.deg_rd0    (deg_rd0),
		.deg_rd1    (deg_rd1),
		.edge_ra    (edge_ra),
		.edge_wa    (edge_wa),
		.edge_wd    (edge_wd),
		.edge_rd    (edge_rd),
		.pos_ra     (pos_ra),
		.pos_wa     (pos_wa),
		.pos_wd     (pos_wd),
		.pos_rd     (pos_rd),
		.slot_ra    (slot_ra),
		.slot_wa    (slot_wa),
		.slot_wd    (slot_wd),
		.slot_rd    (slot_rd)
	);

	elcsr_store #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES)
	) u_store (
		.clk     (clk),
		.ctl     (ctl),
		.deg_ra0 (deg_ra0),
		.deg_ra1 (deg_ra1),
		.deg_wa  (deg_wa),
		.deg_wd  (deg_wd),
		.deg_rd0 (deg_rd0),
		.deg_rd1 (deg_rd1),
		.edge_ra (edge_ra),
		.edge_wa (edge_wa),
		.edge_wd (edge_wd),
		.edge_rd (edge_rd),
		.pos_ra  (pos_ra),
		.pos_wa  (pos_wa),
		.pos_wd  (pos_wd),
		.pos_rd  (pos_rd),
		.slot_ra (slot_ra),
		.slot_wa (slot_wa),
		.slot_wd (slot_wd),
		.slot_rd (slot_rd)
	);

endmodule

// ----- rtl/core/elcsr_checker.sv -----
// Port-level checks of the adjacency builder, bound to its top level.
`include "assert_macros.svh"

module elcsr_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [elcsr_pkg::STATUS_W-1:0]      status,
	input logic [elcsr_pkg::OFFSET_W-1:0]      offset_value,
	input logic [elcsr_pkg::END_W-1:0]         neighbor_vertex,
	input logic [elcsr_pkg::EDGE_NUM_W-1:0]    edge_number
);
	import elcsr_pkg::*;

	// A failed op carries nothing but its status
	`ELCSR_ASSERT_IMP(a_err_fields_zero, clk, arst_n, out_valid && status != ST_OK, offset_value == '0 && neighbor_vertex == '0 && edge_number == '0)

	// An offset result and a slot result never mix in one word
	`ELCSR_ASSERT_IMP(a_result_kinds_apart, clk, arst_n, out_valid, offset_value == '0 || (neighbor_vertex == '0 && edge_number == '0))

	// One op at a time: busy in the cycle after an accepted word
	`ELCSR_ASSERT_NXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// A stalled result holds still
	`ELCSR_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(offset_value) && $stable(neighbor_vertex) && $stable(edge_number))

endmodule

bind edge_list_to_csr_builder elcsr_checker u_elcsr_checker (.*);
